// ----- hw/rtl/stks_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stks_pkg
// Shared constants and item types of the streaming top-K selector.
// ----------------------------------------------------------------------------
package stks_pkg;

  localparam int TOP_K      = 10;
  localparam int INDEX_BITS = 18;
  localparam int SCORE_W    = 32;
  localparam int RANK_W     = 4;
  localparam int CNT_W      = $clog2(TOP_K + 1);

  localparam logic [INDEX_BITS-1:0] INDEX_MAX = {INDEX_BITS{1'b1}};
  localparam logic [CNT_W-1:0]      KEEP_MAX  = CNT_W'(TOP_K);

  typedef logic signed [SCORE_W-1:0] score_t;
  typedef logic [INDEX_BITS-1:0]     index_t;
  typedef logic [CNT_W-1:0]          count_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic                      end_of_vector;
  } in_item_t;

  typedef struct packed {
    logic [RANK_W-1:0]         rank;
    logic [INDEX_BITS-1:0]     token_index;
    logic signed [SCORE_W-1:0] entry_score;
    logic                      final_entry;
    logic                      overflowed;
  } out_item_t;

  // one item handed from the input register to the ranking list
  typedef struct packed {
    logic                      valid;
    logic                      eov;
    logic signed [SCORE_W-1:0] score;
  } proc_t;

endpackage
`default_nettype wire

// ----- hw/rtl/streaming_top_k_selector_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// streaming_top_k_selector_core
// Keeps the best TOP_K scores of a vector and emits them in rank order.
// ----------------------------------------------------------------------------
// The block takes one score per cycle into an input register; from there
// that score is ranked against the sorted list of kept entries (all TOP_K
// compares and the shift run in parallel), so a vector streams in at one item
// per cycle. On the item marked end_of_vector the finished list is copied into
// an output bank and the ranking list clears, so the next vector can start
// right away. The bank drains one result per cycle while out_stall is low:
// rank, token_index, entry_score, final_entry on the last one and overflowed
// if the vector ran past 2^INDEX_BITS elements. A vector of N elements gives
// min(N, TOP_K) results. out_valid is registered: it rises once the end item
// in the input register has loaded the finished list into the output bank.
// The only stall on the input comes from a second end item that reaches the
// input register while the previous run still sits in the bank: that item
// waits until the last result of the previous run is taken.
// ----------------------------------------------------------------------------
module streaming_top_k_selector_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire stks_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output stks_pkg::out_item_t      out_data
);

  // input register
  logic               s1_valid_r;
  stks_pkg::in_item_t s1_data_r;

  // output bank
  stks_pkg::score_t    bank_score_r [stks_pkg::TOP_K];
  stks_pkg::index_t    bank_idx_r   [stks_pkg::TOP_K];
  stks_pkg::count_t    bank_left_r;
  logic [stks_pkg::RANK_W-1:0] bank_rank_r;
  logic                bank_ovf_r;

  stks_pkg::score_t snap_score [stks_pkg::TOP_K];
  stks_pkg::index_t snap_idx   [stks_pkg::TOP_K];
  stks_pkg::count_t snap_cnt;
  logic             snap_ovf;

  stks_pkg::proc_t proc;
  logic out_take, bank_free, s1_hold, in_take, snap_load;

  assign out_take  = out_valid && !out_stall;
  // bank can take a new run once its last result leaves
  assign bank_free = (bank_left_r == '0)
                   || ((bank_left_r == stks_pkg::CNT_W'(1)) && out_take);
  // hold an end item while the previous run is still draining
  assign s1_hold   = s1_valid_r && s1_data_r.end_of_vector && !bank_free;
  assign in_stall  = s1_hold;
  assign in_take   = in_valid && !in_stall;

  assign proc.valid = s1_valid_r && !s1_hold;
  assign proc.eov   = s1_data_r.end_of_vector;
  assign proc.score = s1_data_r.score;
  assign snap_load  = proc.valid && proc.eov;

  stks_list u_list (
    .clk        (clk),
    .rst_n      (rst_n),
    .proc       (proc),
    .snap_score (snap_score),
    .snap_idx   (snap_idx),
    .snap_cnt   (snap_cnt),
    .snap_ovf   (snap_ovf)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (proc.valid) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
  end

  // bank control: load a finished run, or advance one result per take
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_left_r <= '0;
      bank_rank_r <= '0;
      bank_ovf_r  <= 1'b0;
    end else if (snap_load) begin
      bank_left_r <= snap_cnt;
      bank_rank_r <= '0;
      bank_ovf_r  <= snap_ovf;
    end else if (out_take) begin
      bank_left_r <= bank_left_r - 1'b1;
      bank_rank_r <= bank_rank_r + 1'b1;
    end
  end

  // bank payload: shift toward slot 0, which feeds the output
  always_ff @(posedge clk) begin
    if (snap_load) begin
      bank_score_r <= snap_score;
      bank_idx_r   <= snap_idx;
    end else if (out_take) begin
      for (int j = 0; j < stks_pkg::TOP_K - 1; j++) begin
        bank_score_r[j] <= bank_score_r[j+1];
        bank_idx_r[j]   <= bank_idx_r[j+1];
      end
    end
  end

  assign out_valid            = (bank_left_r != '0);
  assign out_data.rank        = bank_rank_r;
  assign out_data.token_index = bank_idx_r[0];
  assign out_data.entry_score = bank_score_r[0];
  assign out_data.final_entry = (bank_left_r == stks_pkg::CNT_W'(1));
  assign out_data.overflowed  = bank_ovf_r;

endmodule
`default_nettype wire

// ----- hw/rtl/stks_list.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stks_list
// Sorted list of the best entries of the current vector, with the element
// counter and overflow tracking. Inserts one item per cycle while proc.valid is high.
// ----------------------------------------------------------------------------
module stks_list (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire stks_pkg::proc_t proc,
  output stks_pkg::score_t    snap_score [stks_pkg::TOP_K],
  output stks_pkg::index_t    snap_idx   [stks_pkg::TOP_K],
  output stks_pkg::count_t    snap_cnt,
  output logic                snap_ovf
);

  stks_pkg::score_t kept_score_r [stks_pkg::TOP_K];
  stks_pkg::index_t kept_idx_r   [stks_pkg::TOP_K];
  stks_pkg::score_t kept_score_nxt [stks_pkg::TOP_K];
  stks_pkg::index_t kept_idx_nxt   [stks_pkg::TOP_K];
  stks_pkg::count_t cnt_r, cnt_nxt;
  stks_pkg::index_t ctr_r, ctr_nxt;
  logic             at_max_r, at_max_nxt;
  logic             ovf_r, ovf_nxt;
  logic [stks_pkg::TOP_K-1:0] ins;

  // counter saturates at the top index; a second use of it marks overflow
  always_comb begin
    ctr_nxt    = ctr_r;
    at_max_nxt = at_max_r;
    ovf_nxt    = ovf_r;
    if (ctr_r != stks_pkg::INDEX_MAX) begin
      ctr_nxt = ctr_r + 1'b1;
    end else begin
      if (at_max_r) begin
        ovf_nxt = 1'b1;
      end
      at_max_nxt = 1'b1;
    end
  end

  // ins[j]: new item belongs at or above slot j (thermometer over a sorted list)
  always_comb begin
    for (int j = 0; j < stks_pkg::TOP_K; j++) begin
      ins[j] = (stks_pkg::CNT_W'(j) >= cnt_r)
             || (proc.score > kept_score_r[j])
             || ((proc.score == kept_score_r[j]) && (ctr_r < kept_idx_r[j]));
    end
  end

  always_comb begin
    for (int j = 0; j < stks_pkg::TOP_K; j++) begin
      kept_score_nxt[j] = kept_score_r[j];
      kept_idx_nxt[j]   = kept_idx_r[j];
      if (ins[j]) begin
        if (j == 0) begin
          kept_score_nxt[j] = proc.score;
          kept_idx_nxt[j]   = ctr_r;
        end else if (!ins[j-1]) begin
          kept_score_nxt[j] = proc.score;
          kept_idx_nxt[j]   = ctr_r;
        end else begin
          kept_score_nxt[j] = kept_score_r[j-1];
          kept_idx_nxt[j]   = kept_idx_r[j-1];
        end
      end
    end
    cnt_nxt = (cnt_r == stks_pkg::KEEP_MAX) ? cnt_r : cnt_r + 1'b1;
  end

  assign snap_score = kept_score_nxt;
  assign snap_idx   = kept_idx_nxt;
  assign snap_cnt   = cnt_nxt;
  assign snap_ovf   = ovf_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      ctr_r    <= '0;
      at_max_r <= 1'b0;
      ovf_r    <= 1'b0;
    end else if (proc.valid) begin
      if (proc.eov) begin
        cnt_r    <= '0;
        ctr_r    <= '0;
        at_max_r <= 1'b0;
        ovf_r    <= 1'b0;
      end else begin
        cnt_r    <= cnt_nxt;
        ctr_r    <= ctr_nxt;
        at_max_r <= at_max_nxt;
        ovf_r    <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc.valid) begin
      kept_score_r <= kept_score_nxt;
      kept_idx_r   <= kept_idx_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/stks_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stks_checker
// Port-level checks of the top-K selector's result stream.
// ----------------------------------------------------------------------------
module stks_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire stks_pkg::out_item_t out_data
);

  logic out_take;
  assign out_take = out_valid && !out_stall;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // results of one run follow back to back with rising rank
  a_rank_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_take && !out_data.final_entry |=>
      out_valid && (out_data.rank == $past(out_data.rank) + 1'b1))
    else $error("rank did not advance within a run");

  // a new run starts at rank zero
  a_rank_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_take && out_data.final_entry |=> !out_valid || (out_data.rank == '0))
    else $error("run did not restart at rank zero");

  // overflow flag is constant over a run
  a_ovf_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_take && !out_data.final_entry |=>
      out_data.overflowed == $past(out_data.overflowed))
    else $error("overflow flag changed within a run");

  // no more than TOP_K results per run
  a_rank_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.rank < stks_pkg::RANK_W'(stks_pkg::TOP_K)))
    else $error("rank beyond list depth");

endmodule

bind streaming_top_k_selector_core stks_checker u_stks_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
